>>> src/sorted_timer_expiry_queue_assert.svh
// assertion macros for the sorted timer expiry queue
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef SORTED_TIMER_EXPIRY_QUEUE_ASSERT_SVH
`define SORTED_TIMER_EXPIRY_QUEUE_ASSERT_SVH

// same-cycle implication
`define STQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/stq_pkg.sv
// shared types, constants and helpers of the sorted timer expiry queue
// no dependencies
package stq_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int TID_W          = 4;
  localparam int TICK_W         = 32;
  localparam int OP_W           = 2;
  localparam int MAX_FIRE       = 16;
  localparam int FIRE_IDX_W     = $clog2(MAX_FIRE);
  localparam int FIRE_CNT_W     = FIRE_IDX_W + 1;

  localparam logic [OP_W-1:0] OP_ARM  = 2'd0;
  localparam logic [OP_W-1:0] OP_STOP = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_REMOVE,
    CELL_INSERT,
    CELL_POP
  } cell_op_e;

  // one list position
  typedef struct packed {
    logic              valid;
    logic [TID_W-1:0]  id;
    logic [TICK_W-1:0] expiry;
  } entry_t;

  // command broadcast to every cell
  typedef struct packed {
    cell_op_e          op;
    logic [TID_W-1:0]  id;
    logic [TICK_W-1:0] expiry;
  } cell_cmd_t;

  // a is before b when a - b is negative
  function automatic logic tick_lt(input logic [TICK_W-1:0] a, input logic [TICK_W-1:0] b);
    logic [TICK_W-1:0] diff;
    diff = a - b;
    return diff[TICK_W-1];
  endfunction

endpackage

>>> src/sorted_timer_expiry_queue.sv
// steps: arm runs stop, insert and finish before its first result beat; stop runs stop and
//   finish; a tick pops each fired timer then finishes; rejects, other opcodes finish
// throughput: one item at a time, the next beat is taken after the last result beat
//   leaves; an arm costs two passes through the cell chain (remove, then insert)
// reset: asynchronous active low, empties the list and drops any pending result
// the list is a chain of NUM_TIMERS cells, head at cell 0, kept sorted by expiry
module sorted_timer_expiry_queue import stq_pkg::*; #(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command beats
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,   // timer_id[3:0], delay_ticks[35:4], now[67:36], zero
  input  logic [1:0]  s_axis_tuser_i,   // opcode[1:0]
  // result beats
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // status[0], fired[1], fired_timer[5:2],
                                        // wakeup_ticks[37:6], zero
  output logic        m_axis_tlast_o
);

`include "sorted_timer_expiry_queue_assert.svh"

  // one-hot sequencer
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_STOP   = 6'b000010,
    ST_INSERT = 6'b000100,
    ST_POP    = 6'b001000,
    ST_FINISH = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // latched command
  logic [OP_W-1:0]   op_q;
  logic [TID_W-1:0]  id_q;
  logic [TICK_W-1:0] delay_q;
  logic [TICK_W-1:0] now_q;
  logic [TICK_W-1:0] when_q;
  logic              status_q;

  // fired slots of the current tick, emitted after the list settles
  logic [TID_W-1:0]      fire_buf_q [MAX_FIRE];
  logic [TID_W-1:0]      fire_id_q;
  logic [FIRE_CNT_W-1:0] fire_cnt_q;
  logic [FIRE_IDX_W-1:0] rd_idx_q;

  logic [TICK_W-1:0] wake_q;
  logic              m_valid_q;

  // cell chain wiring
  entry_t                ent [NUM_TIMERS];
  logic [NUM_TIMERS:0]   found_c;
  logic [NUM_TIMERS:0]   removed_c;
  logic [NUM_TIMERS-1:0] valid_vec;
  cell_cmd_t             cmd;

  logic s_hs, m_hs;
  logic id_ok;
  logic pop_go;
  logic full;
  logic [FIRE_CNT_W-1:0] total;
  logic                  is_last;
  logic [TICK_W-1:0]     head_diff;

  assign s_hs  = s_axis_tvalid_i && s_axis_tready_o;
  assign m_hs  = m_valid_q && m_axis_tready_i;
  assign id_ok = 32'(s_axis_tdata_i[TID_W-1:0]) < 32'(NUM_TIMERS);
  assign full  = ent[NUM_TIMERS-1].valid;

  // head has expired and the per-tick limit is not reached
  assign pop_go = ent[0].valid && !tick_lt(now_q, ent[0].expiry)
                  && (fire_cnt_q != FIRE_CNT_W'(MAX_FIRE));

  assign found_c[0]   = 1'b0;
  assign removed_c[0] = 1'b0;

  // broadcast command to the chain
  always_comb begin
    cmd.id     = id_q;
    cmd.expiry = when_q;
    case (state_q)
      ST_STOP:   cmd.op = CELL_REMOVE;
      ST_INSERT: cmd.op = full ? CELL_HOLD : CELL_INSERT;
      ST_POP:    cmd.op = pop_go ? CELL_POP : CELL_HOLD;
      default:   cmd.op = CELL_HOLD;
    endcase
  end

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    entry_t left_e, right_e;
    if (g == 0) begin : g_head
      assign left_e = '0;
    end else begin : g_mid
      assign left_e = ent[g-1];
    end
    if (g == NUM_TIMERS - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_body
      assign right_e = ent[g+1];
    end
    stq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .left_i    (left_e),
      .right_i   (right_e),
      .found_i   (found_c[g]),
      .removed_i (removed_c[g]),
      .found_o   (found_c[g+1]),
      .removed_o (removed_c[g+1]),
      .entry_o   (ent[g])
    );
    assign valid_vec[g] = ent[g].valid;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_hs) begin
          if (s_axis_tuser_i == OP_ARM) begin
            if (s_axis_tdata_i[TID_W+TICK_W-1]) state_d = ST_FINISH;
            else if (id_ok)                     state_d = ST_STOP;
            else                                state_d = ST_FINISH;
          end else if (s_axis_tuser_i == OP_STOP) begin
            state_d = id_ok ? ST_STOP : ST_FINISH;
          end else if (s_axis_tuser_i == OP_TICK) begin
            state_d = ST_POP;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_STOP:   state_d = (op_q == OP_ARM) ? ST_INSERT : ST_FINISH;
      ST_INSERT: state_d = ST_FINISH;
      ST_POP:    state_d = pop_go ? ST_POP : ST_FINISH;
      ST_FINISH: state_d = ST_EMIT;
      ST_EMIT: begin
        if (m_hs && is_last) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fire_cnt_q <= '0;
      rd_idx_q   <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (s_hs) begin
        fire_cnt_q <= '0;
        rd_idx_q   <= '0;
      end
      if (state_q == ST_POP && pop_go) fire_cnt_q <= fire_cnt_q + 1'b1;
      if (state_q == ST_FINISH) m_valid_q <= 1'b1;
      if (state_q == ST_EMIT && m_hs) begin
        if (is_last) m_valid_q <= 1'b0;
        else         rd_idx_q  <= rd_idx_q + 1'b1;
      end
    end
  end

  // payload registers
  assign head_diff = ent[0].expiry - now_q;

  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      op_q     <= s_axis_tuser_i;
      id_q     <= s_axis_tdata_i[TID_W-1:0];
      delay_q  <= s_axis_tdata_i[TID_W+TICK_W-1:TID_W];
      now_q    <= s_axis_tdata_i[TID_W+2*TICK_W-1:TID_W+TICK_W];
      // negative delay on arm is rejected and leaves the list alone
      status_q <= (s_axis_tuser_i == OP_ARM) && s_axis_tdata_i[TID_W+TICK_W-1];
    end
    // zero delay counts as one tick
    if (state_q == ST_STOP) begin
      when_q <= now_q + ((delay_q == '0) ? TICK_W'(1) : delay_q);
    end
    if (state_q == ST_POP && pop_go) begin
      fire_buf_q[fire_cnt_q[FIRE_IDX_W-1:0]] <= ent[0].id;
    end
    // registered read of the fired slots, one step ahead of the beat index
    if (state_q == ST_FINISH) begin
      fire_id_q <= fire_buf_q[0];
    end
    if (state_q == ST_EMIT && m_hs && !is_last) begin
      fire_id_q <= fire_buf_q[rd_idx_q + 1'b1];
    end
    // ticks to the earliest expiry, zero if already past, all ones if empty
    if (state_q == ST_FINISH) begin
      if (!ent[0].valid)            wake_q <= '1;
      else if (head_diff[TICK_W-1]) wake_q <= '0;
      else                          wake_q <= head_diff;
    end
  end

  // result fields
  assign total   = (fire_cnt_q == '0) ? FIRE_CNT_W'(1) : fire_cnt_q;
  assign is_last = ({1'b0, rd_idx_q} + 1'b1) == total;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tlast_o  = is_last;
  assign m_axis_tdata_o  = {2'b00, wake_q,
                            (fire_cnt_q != '0) ? fire_id_q : TID_W'(0),
                            (fire_cnt_q != '0), status_q};

  // list stays packed toward the head
  `STQ_ASSERT_IMPL(a_list_packed, 1'b1, ((valid_vec >> 1) & ~valid_vec) == '0,
                   "stq: hole in the timer list")
  // never take a command while a result waits
  `STQ_ASSERT_IMPL(a_one_item, s_axis_tready_o, !m_axis_tvalid_o,
                   "stq: command taken while a result is pending")
  // each pop records exactly one fired slot
  `STQ_ASSERT_NEXT(a_pop_count, state_q == ST_POP && pop_go,
                   fire_cnt_q == $past(fire_cnt_q) + 1'b1,
                   "stq: fire count did not advance on pop")
  // fire count bounded by the per-tick limit
  `STQ_ASSERT_IMPL(a_fire_bound, 1'b1, fire_cnt_q <= FIRE_CNT_W'(MAX_FIRE),
                   "stq: too many fired timers in one tick")

endmodule

>>> src/stq_cell.sv
// one position of the sorted timer list
// depends on stq_pkg
module stq_cell import stq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_cmd_t cmd_i,
  input  entry_t    left_i,     // entry of the position closer to the head
  input  entry_t    right_i,    // entry of the position further from the head
  input  logic      found_i,    // insert point lies at an earlier position
  input  logic      removed_i,  // removed slot lies at an earlier position
  output logic      found_o,
  output logic      removed_o,
  output entry_t    entry_o
);

  entry_t entry_q, entry_d;
  logic   match;
  logic   here;

  assign match     = entry_q.valid && (entry_q.id == cmd_i.id);
  assign here      = !entry_q.valid || tick_lt(cmd_i.expiry, entry_q.expiry);
  assign removed_o = removed_i | match;
  assign found_o   = found_i | here;
  assign entry_o   = entry_q;

  always_comb begin
    entry_d = entry_q;
    case (cmd_i.op)
      CELL_REMOVE: begin
        if (removed_i || match) entry_d = right_i;
      end
      CELL_INSERT: begin
        if (found_i) begin
          entry_d = left_i;
        end else if (here) begin
          entry_d.valid  = 1'b1;
          entry_d.id     = cmd_i.id;
          entry_d.expiry = cmd_i.expiry;
        end
      end
      CELL_POP: entry_d = right_i;
      default:  entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

endmodule
